>>> hw/rtl/sem_pkg.sv
package sem_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int MIN_DIM      = 3;
    localparam int PIX_W        = 8;
    localparam int MAG_MAX      = 255;

    // depth of the result-record queue, also the bound on items in flight
    localparam int REC_DEPTH = 8;
    localparam int REC_PTR_W = $clog2(REC_DEPTH);

    // register map, one word per register
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    // results an item can cause, lowest bit goes out first
    localparam logic [2:0] EMIT_SOBEL = 3'b001;  // (r-1, c-1) magnitude
    localparam logic [2:0] EMIT_EDGE  = 3'b010;  // (r-1, c) left/right border
    localparam logic [2:0] EMIT_HERE  = 3'b100;  // (r, c) first/last row border

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [2:0]       emit;
    } ctx_t;

    typedef struct packed {
        ctx_t             ctx;
        logic [PIX_W-1:0] mag;
    } rec_t;

    typedef struct packed {
        logic [10:0] rem;
        logic [7:0]  root;
    } sqrt_state_t;

    // |a - b| saturated to 255
    function automatic logic [PIX_W-1:0] sat_absdiff(logic [9:0] a, logic [9:0] b);
        logic [9:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return (d > 10'(MAG_MAX)) ? PIX_W'(MAG_MAX) : d[PIX_W-1:0];
    endfunction

    // four digit steps of the restoring square root, two radicand bits each
    function automatic sqrt_state_t sqrt_4steps(sqrt_state_t s, logic [7:0] bits);
        sqrt_state_t t;
        logic [10:0] trial;
        t = s;
        for (int i = 3; i >= 0; i--)
        begin
            t.rem = {t.rem[8:0], bits[2*i+1 -: 2]};
            trial = {1'b0, t.root, 2'b01};
            if (t.rem >= trial)
            begin
                t.rem  = t.rem - trial;
                t.root = {t.root[6:0], 1'b1};
            end
            else
            begin
                t.root = {t.root[6:0], 1'b0};
            end
        end
        return t;
    endfunction

endpackage

>>> hw/rtl/sobel_edge_magnitude.sv
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata[7:0] pixel
// m_axis    out  m_axis_tvalid/tready       tdata: magnitude, out_row, out_col; tlast
// apb       in   psel/penable/pwrite/pready paddr[2] selects width/height
//
// One pixel per clock accepted while fewer than 8 items are in flight; each
// pixel causes 0..3 results and m_axis moves one result per clock while
// m_axis_tready is high, so the result port sets the sustained rate (extra
// cycles at row ends, last row). The first result passes the line-store read,
// gradient, square, sum, upper root half, lower root half into the queue and
// the output register in that order. Reset clears position, pipeline and queue;
// the line store is not cleared. m_axis stalls back up into the record queue.
module sobel_edge_magnitude
    import sem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] magnitude, [19:8] out_row, [29:20] out_col
    output logic        m_axis_tlast,   // last_of_item

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    logic [WIDTH_REG_W-1:0]  image_width_reg;
    logic [HEIGHT_REG_W-1:0] image_height_reg;
    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_REG_W'(512);
            image_height_reg <= HEIGHT_REG_W'(512);
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    // out-of-range sizes saturate into the legal range
    always_comb
    begin
        if (image_width_reg < WIDTH_REG_W'(MIN_DIM))
            w_eff = WIDTH_REG_W'(MIN_DIM);
        else if (image_width_reg > WIDTH_REG_W'(MAX_WIDTH))
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        else
            w_eff = image_width_reg;

        if (image_height_reg < HEIGHT_REG_W'(MIN_DIM))
            h_eff = HEIGHT_REG_W'(MIN_DIM);
        else if (image_height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        else
            h_eff = image_height_reg;
    end

    // ---------------------------------------------------------------
    // input side: raster position and result flags
    // ---------------------------------------------------------------
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [REC_PTR_W:0]   inflight_reg;
    logic                 in_accept;
    logic                 pop;
    logic                 c_last, r_last, r_ge2;
    ctx_t                 ctx_in;

    assign s_axis_tready = inflight_reg < (REC_PTR_W+1)'(REC_DEPTH);
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    assign c_last = WIDTH_REG_W'(col_reg) == (w_eff - WIDTH_REG_W'(1));
    assign r_last = HEIGHT_REG_W'(row_reg) == (h_eff - HEIGHT_REG_W'(1));
    assign r_ge2  = row_reg >= ROW_W'(2);

    always_comb
    begin
        ctx_in.row  = row_reg;
        ctx_in.col  = col_reg;
        ctx_in.emit = ({3{r_ge2 && (col_reg >= COL_W'(2))}}          & EMIT_SOBEL)
                    | ({3{r_ge2 && ((col_reg == '0) || c_last)}}     & EMIT_EDGE)
                    | ({3{(row_reg == '0) || (r_ge2 && r_last)}}     & EMIT_HERE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr)
        begin
            // any register write restarts the frame
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            if (c_last)
            begin
                col_reg <= '0;
                row_reg <= r_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_reg + (REC_PTR_W+1)'(in_accept)
                          - (REC_PTR_W+1)'(pop);
    end

    // ---------------------------------------------------------------
    // line store: {older, newer} per column, read on accept,
    // written back in the following cycle. Consecutive items touch different
    // columns, so the write never lands on the entry being read.
    // ---------------------------------------------------------------
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] line_q_reg;
    logic               v1_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    ctx_t               s1_ctx_reg;
    logic [PIX_W-1:0]   top, mid, bot;

    assign top = line_q_reg[2*PIX_W-1:PIX_W];
    assign mid = line_q_reg[PIX_W-1:0];
    assign bot = s1_pix_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
            line_q_reg <= line_mem[col_reg];
        if (v1_reg)
            line_mem[s1_ctx_reg.col] <= {mid, bot};
    end

    // ---------------------------------------------------------------
    // stage 1: window and gradients
    // win_reg[0..2] column c-2 (top, mid, bot), win_reg[3..5] column c-1
    // ---------------------------------------------------------------
    logic [PIX_W-1:0] win_reg [6];
    logic [9:0]       pos_y, neg_y, pos_x, neg_x;

    assign pos_y = 10'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + 10'(top);
    assign neg_y = 10'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + 10'(bot);
    assign pos_x = 10'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + 10'(win_reg[2]);
    assign neg_x = 10'(top) + {1'b0, mid, 1'b0} + 10'(bot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (v1_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= bot;
        end
    end

    // ---------------------------------------------------------------
    // stages 2..5: abs, squares, sum, root in two halves
    // ---------------------------------------------------------------
    logic             v2_reg, v3_reg, v4_reg, v5_reg;
    ctx_t             s2_ctx_reg, s3_ctx_reg, s4_ctx_reg, s5_ctx_reg;
    logic [PIX_W-1:0] s2_ay_reg, s2_ax_reg;
    logic [15:0]      s3_sqy_reg, s3_sqx_reg;
    logic [16:0]      s4_sum_reg;
    logic             s5_sat_reg;
    logic [7:0]       s5_lo_reg;
    sqrt_state_t      s5_state_reg;
    sqrt_state_t      sqrt_hi, sqrt_lo;

    assign sqrt_hi = sqrt_4steps('0, s4_sum_reg[15:8]);
    assign sqrt_lo = sqrt_4steps(s5_state_reg, s5_lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pix_reg   <= s_axis_tdata;
        s1_ctx_reg   <= ctx_in;
        s2_ctx_reg   <= s1_ctx_reg;
        s2_ay_reg    <= sat_absdiff(pos_y, neg_y);
        s2_ax_reg    <= sat_absdiff(pos_x, neg_x);
        s3_ctx_reg   <= s2_ctx_reg;
        s3_sqy_reg   <= s2_ay_reg * s2_ay_reg;
        s3_sqx_reg   <= s2_ax_reg * s2_ax_reg;
        s4_ctx_reg   <= s3_ctx_reg;
        s4_sum_reg   <= 17'(s3_sqy_reg) + 17'(s3_sqx_reg);
        s5_ctx_reg   <= s4_ctx_reg;
        s5_sat_reg   <= s4_sum_reg[16];  // root >= 256 clamps
        s5_lo_reg    <= s4_sum_reg[7:0];
        s5_state_reg <= sqrt_hi;
    end

    // ---------------------------------------------------------------
    // record queue, one record per item
    // ---------------------------------------------------------------
    rec_t               rec_mem [REC_DEPTH];
    rec_t               rec_in, head;
    logic [REC_PTR_W:0] wr_ptr_reg, rd_ptr_reg;
    logic               head_valid;

    assign rec_in.ctx = s5_ctx_reg;
    assign rec_in.mag = s5_sat_reg ? PIX_W'(MAG_MAX) : sqrt_lo.root;

    always_ff @(posedge clk)
    begin
        if (v5_reg)
            rec_mem[wr_ptr_reg[REC_PTR_W-1:0]] <= rec_in;
    end

    assign head       = rec_mem[rd_ptr_reg[REC_PTR_W-1:0]];
    assign head_valid = wr_ptr_reg != rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (v5_reg)
                wr_ptr_reg <= wr_ptr_reg + (REC_PTR_W+1)'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + (REC_PTR_W+1)'(1);
        end
    end

    // ---------------------------------------------------------------
    // result serializer and output register
    // ---------------------------------------------------------------
    logic [2:0]       done_reg;
    logic [2:0]       remaining, sel, rest;
    logic             out_valid_reg, out_last_reg, out_free, emit_now;
    logic [PIX_W-1:0] out_mag_reg, res_mag;
    logic [ROW_W-1:0] out_row_reg, res_row;
    logic [COL_W-1:0] out_col_reg, res_col;

    assign remaining = head.ctx.emit & ~done_reg;
    assign sel       = remaining & (~remaining + 3'd1);
    assign rest      = remaining & ~sel;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign emit_now  = head_valid && (remaining != '0) && out_free;
    assign pop       = head_valid && ((remaining == '0) || (out_free && (rest == '0)));

    always_comb
    begin
        case (sel)
            EMIT_SOBEL:
            begin
                res_mag = head.mag;
                res_row = head.ctx.row - ROW_W'(1);
                res_col = head.ctx.col - COL_W'(1);
            end
            EMIT_EDGE:
            begin
                res_mag = '0;
                res_row = head.ctx.row - ROW_W'(1);
                res_col = head.ctx.col;
            end
            EMIT_HERE:
            begin
                res_mag = '0;
                res_row = head.ctx.row;
                res_col = head.ctx.col;
            end
            default:
            begin
                res_mag = '0;
                res_row = '0;
                res_col = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                done_reg <= '0;
            else if (emit_now)
                done_reg <= done_reg | sel;
            if (out_free)
                out_valid_reg <= emit_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_now)
        begin
            out_mag_reg  <= res_mag;
            out_row_reg  <= res_row;
            out_col_reg  <= res_col;
            out_last_reg <= rest == '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_col_reg, out_row_reg, out_mag_reg};
    assign m_axis_tlast  = out_last_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= (REC_PTR_W+1)'(REC_DEPTH))
        else $error("items in flight exceed record queue depth");

    a_queue_le_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) <= inflight_reg)
        else $error("record queue holds more than items in flight");

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        (WIDTH_REG_W'(col_reg) < w_eff) && (HEIGHT_REG_W'(row_reg) < h_eff))
        else $error("raster position outside frame");

    a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ((done_reg & ~head.ctx.emit) == '0))
        else $error("serializer marked a result the head record does not have");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (done_reg == '0))
        else $error("serializer progress left over with empty queue");

endmodule
